// File: src/bbc_pkg.sv
`default_nettype none
package bbc_pkg;

    // field widths
    localparam int POS_W  = 31;
    localparam int VEL_W  = 25;
    localparam int CNT_W  = 16;
    localparam int PIX_W  = 15;
    localparam int FRAC_W = 16;
    localparam int MODE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [VEL_W-1:0]  t_vel;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [MODE_W-1:0]        t_mode;

    // mode codes
    localparam t_mode MODE_MOVING = 2'd0;
    localparam t_mode MODE_STILL  = 2'd1;
    localparam t_mode MODE_BLINK  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOVING_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_TICKS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINKING_TICKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 3'd7;

    // register reset values
    localparam t_pos RST_X_LIMIT        = 31'd20905984;
    localparam t_pos RST_Y_LIMIT        = 31'd15663104;
    localparam t_vel RST_START_STEP     = 25'sd65536;
    localparam t_cnt RST_MOVING_TICKS   = 16'd300;
    localparam t_cnt RST_STILL_TICKS    = 16'd100;
    localparam t_cnt RST_BLINKING_TICKS = 16'd200;
    localparam t_cnt RST_BLINK_PERIOD   = 16'd10;

    // saturation points of the velocity
    localparam t_vel VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam t_vel VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

endpackage
`default_nettype wire

// File: src/bouncing_blinking_cursor.sv
`default_nettype none
// bouncing, blinking cursor animator
// each request on the input channel (i_in_valid, o_in_stall, i_restart) is one
// animation tick; each tick yields exactly one result request on the output
// channel (o_out_valid, i_out_stall, pixel position, mode and visibility).
// i_restart reloads position 0, the start velocity, moving mode and visibility.
// the result is registered and valid in the cycle after its tick is accepted.
// throughput: one tick per cycle while o_in_stall is low; the whole position,
// velocity and sequencer update is one adder and two compares per axis plus
// counter decrements feeding the state and output registers.
// when the receiver stalls the result register holds its value and a new tick
// is still taken in the same cycle the held result is taken, so o_in_stall is
// high only while a result waits and i_out_stall is high.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at a clock
// edge; registers must be written only while idle, which the block never checks.
// synchronous active-low reset returns registers to their defaults, position
// and velocity to zero, moving mode with countdowns of one, cursor visible,
// and an empty output register.
module bouncing_blinking_cursor (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // configuration write port
    input  wire                           i_cfg_we,
    input  wire [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // tick channel
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_restart,
    // result channel
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic [bbc_pkg::PIX_W-1:0]     o_pixel_x,
    output logic [bbc_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                          o_position_updated,
    output logic                          o_shown,
    output logic                          o_visibility_written,
    output logic [bbc_pkg::MODE_W-1:0]    o_mode_now
);
    import bbc_pkg::*;

    // configuration registers
    t_pos r_x_limit, r_y_limit;
    t_vel r_start_step_x, r_start_step_y;
    t_cnt r_moving_ticks, r_still_ticks, r_blinking_ticks, r_blink_period;

    // animation state
    t_pos  r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    t_vel  r_vel_x, r_vel_y, n_vel_x, n_vel_y;
    t_mode r_mode, n_mode;
    t_cnt  r_mode_cnt, n_mode_cnt;
    t_cnt  r_blink_cnt, n_blink_cnt;
    logic  r_visible, n_visible;
    logic  n_moved, n_vis_wr;

    // output register
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_pixel_x, r_pixel_y;
    logic               r_moved, r_shown, r_vis_wr;
    t_mode              r_mode_now;

    t_pos adv_pos_x, adv_pos_y;
    t_vel adv_vel_x, adv_vel_y;
    logic accept;
    logic mode_expired, blink_expired;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit        <= RST_X_LIMIT;
            r_y_limit        <= RST_Y_LIMIT;
            r_start_step_x   <= RST_START_STEP;
            r_start_step_y   <= RST_START_STEP;
            r_moving_ticks   <= RST_MOVING_TICKS;
            r_still_ticks    <= RST_STILL_TICKS;
            r_blinking_ticks <= RST_BLINKING_TICKS;
            r_blink_period   <= RST_BLINK_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_LIMIT:        r_x_limit        <= i_cfg_data[POS_W-1:0];
                REG_Y_LIMIT:        r_y_limit        <= i_cfg_data[POS_W-1:0];
                REG_START_STEP_X:   r_start_step_x   <= i_cfg_data[VEL_W-1:0];
                REG_START_STEP_Y:   r_start_step_y   <= i_cfg_data[VEL_W-1:0];
                REG_MOVING_TICKS:   r_moving_ticks   <= i_cfg_data[CNT_W-1:0];
                REG_STILL_TICKS:    r_still_ticks    <= i_cfg_data[CNT_W-1:0];
                REG_BLINKING_TICKS: r_blinking_ticks <= i_cfg_data[CNT_W-1:0];
                REG_BLINK_PERIOD:   r_blink_period   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // per-axis advance with bounce
    bbc_axis u_axis_x (
        .i_pos   (r_pos_x),
        .i_vel   (r_vel_x),
        .i_limit (r_x_limit),
        .o_pos   (adv_pos_x),
        .o_vel   (adv_vel_x)
    );

    bbc_axis u_axis_y (
        .i_pos   (r_pos_y),
        .i_vel   (r_vel_y),
        .i_limit (r_y_limit),
        .o_pos   (adv_pos_y),
        .o_vel   (adv_vel_y)
    );

    // a count of zero or one expires
    assign mode_expired  = (r_mode_cnt[CNT_W-1:1] == '0);
    assign blink_expired = (r_blink_cnt[CNT_W-1:1] == '0);

    // next state for one tick
    always_comb begin
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_vel_x     = r_vel_x;
        n_vel_y     = r_vel_y;
        n_mode      = r_mode;
        n_mode_cnt  = r_mode_cnt;
        n_blink_cnt = r_blink_cnt;
        n_visible   = r_visible;
        n_moved     = 1'b0;
        n_vis_wr    = 1'b0;
        if (i_restart) begin
            n_pos_x     = '0;
            n_pos_y     = '0;
            n_vel_x     = r_start_step_x;
            n_vel_y     = r_start_step_y;
            n_mode      = MODE_MOVING;
            n_mode_cnt  = r_moving_ticks;
            n_blink_cnt = r_blink_period;
            n_visible   = 1'b1;
            n_vis_wr    = 1'b1;
        end else begin
            // position advances in every mode but stationary
            if (r_mode != MODE_STILL) begin
                n_pos_x = adv_pos_x;
                n_pos_y = adv_pos_y;
                n_vel_x = adv_vel_x;
                n_vel_y = adv_vel_y;
                n_moved = 1'b1;
            end
            case (r_mode)
                MODE_MOVING: begin
                    if (mode_expired) begin
                        n_mode     = MODE_STILL;
                        n_mode_cnt = r_still_ticks;
                    end else begin
                        n_mode_cnt = r_mode_cnt - 1'b1;
                    end
                end
                MODE_STILL: begin
                    if (mode_expired) begin
                        n_mode      = MODE_BLINK;
                        n_mode_cnt  = r_blinking_ticks;
                        n_blink_cnt = r_blink_period;
                    end else begin
                        n_mode_cnt = r_mode_cnt - 1'b1;
                    end
                end
                MODE_BLINK: begin
                    if (mode_expired) begin
                        n_mode     = MODE_MOVING;
                        n_mode_cnt = r_moving_ticks;
                        n_visible  = 1'b1;
                        n_vis_wr   = 1'b1;
                    end else begin
                        n_mode_cnt = r_mode_cnt - 1'b1;
                        if (blink_expired) begin
                            n_blink_cnt = r_blink_period;
                            n_visible   = !r_visible;
                            n_vis_wr    = 1'b1;
                        end else begin
                            n_blink_cnt = r_blink_cnt - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_mode      <= MODE_MOVING;
            r_mode_cnt  <= t_cnt'(1);
            r_blink_cnt <= t_cnt'(1);
            r_visible   <= 1'b1;
        end else if (accept) begin
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_vel_x     <= n_vel_x;
            r_vel_y     <= n_vel_y;
            r_mode      <= n_mode;
            r_mode_cnt  <= n_mode_cnt;
            r_blink_cnt <= n_blink_cnt;
            r_visible   <= n_visible;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel_x  <= n_pos_x[POS_W-1:FRAC_W];
            r_pixel_y  <= n_pos_y[POS_W-1:FRAC_W];
            r_moved    <= n_moved;
            r_shown    <= n_visible;
            r_vis_wr   <= n_vis_wr;
            r_mode_now <= n_mode;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_pixel_x            = r_pixel_x;
    assign o_pixel_y            = r_pixel_y;
    assign o_position_updated   = r_moved;
    assign o_shown              = r_shown;
    assign o_visibility_written = r_vis_wr;
    assign o_mode_now           = r_mode_now;

endmodule
`default_nettype wire

// File: src/bbc_axis.sv
`default_nettype none
module bbc_axis (
    input  wire bbc_pkg::t_pos i_pos,
    input  wire bbc_pkg::t_vel i_vel,
    input  wire bbc_pkg::t_pos i_limit,
    output bbc_pkg::t_pos      o_pos,
    output bbc_pkg::t_vel      o_vel
);
    import bbc_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic [SUM_W-1:0] sum;
    logic             hit_low;
    logic             hit_high;
    t_vel             vel_neg;

    // wide sum of position and sign-extended velocity, never wraps
    assign sum = {2'b00, i_pos} + {{(SUM_W-VEL_W){i_vel[VEL_W-1]}}, i_vel};

    // low side is tested first
    assign hit_low  = sum[SUM_W-1] || (sum == '0);
    assign hit_high = (sum[SUM_W-2:0] >= {1'b0, i_limit});

    // negate with saturation of the most negative value
    assign vel_neg = (i_vel == VEL_MIN) ? VEL_MAX : -i_vel;

    always_comb begin
        if (hit_low) begin
            o_pos = '0;
            o_vel = vel_neg;
        end else if (hit_high) begin
            o_pos = i_limit;
            o_vel = vel_neg;
        end else begin
            o_pos = sum[POS_W-1:0];
            o_vel = i_vel;
        end
    end

endmodule
`default_nettype wire
